// File: rtl/mwam_pkg.sv
// ----------------------------------------------------------------------------
// mwam_pkg
// Shared types and constants for the magnetometer window alarm monitor.
// ----------------------------------------------------------------------------
package mwam_pkg;

    // counter thresholds
    localparam logic [7:0] TRIGGER_LEVEL = 8'd4;
    localparam logic [7:0] TRIGGER_MAX   = 8'd8;

    // field widths
    localparam int AXIS_W = 16;
    localparam int NORM_W = 8;
    localparam int SQ_W   = 31;
    localparam int STR_W  = 32;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // register indexes
    localparam logic [2:0] REG_OFFSET_X  = 3'd0;
    localparam logic [2:0] REG_OFFSET_Y  = 3'd1;
    localparam logic [2:0] REG_OFFSET_Z  = 3'd2;
    localparam logic [2:0] REG_SHIFT_X   = 3'd3;
    localparam logic [2:0] REG_SHIFT_Y   = 3'd4;
    localparam logic [2:0] REG_SHIFT_Z   = 3'd5;
    localparam logic [2:0] REG_LOW_THR   = 3'd6;
    localparam logic [2:0] REG_HIGH_THR  = 3'd7;

    // configuration seen by the datapath
    typedef struct packed {
        logic signed [AXIS_W-1:0] offset_x;
        logic signed [AXIS_W-1:0] offset_y;
        logic signed [AXIS_W-1:0] offset_z;
        logic [3:0]               shift_x;
        logic [3:0]               shift_y;
        logic [3:0]               shift_z;
        logic [STR_W-1:0]         low_thr;
        logic [STR_W-1:0]         high_thr;
    } mwam_cfg_t;

    // item between the square stage and the window stage
    typedef struct packed {
        logic signed [NORM_W-1:0] norm_x;
        logic signed [NORM_W-1:0] norm_y;
        logic signed [NORM_W-1:0] norm_z;
        logic [SQ_W-1:0]          sq_x;
        logic [SQ_W-1:0]          sq_y;
        logic [SQ_W-1:0]          sq_z;
        logic                     ovf;
    } mwam_sq_t;

endpackage

// File: rtl/mwam_regs.sv
// ----------------------------------------------------------------------------
// mwam_regs
// APB-style register file holding offsets, shifts and window thresholds.
// ----------------------------------------------------------------------------
module mwam_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mwam_pkg::ADDR_W-1:0]   paddr,
    input  logic [mwam_pkg::DATA_W-1:0]   pwdata,
    output logic [mwam_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output mwam_pkg::mwam_cfg_t           cfg
);
    import mwam_pkg::*;

    mwam_cfg_t  cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_x <= '0;
            cfg_reg.offset_y <= '0;
            cfg_reg.offset_z <= '0;
            cfg_reg.shift_x  <= 4'd1;
            cfg_reg.shift_y  <= 4'd1;
            cfg_reg.shift_z  <= 4'd1;
            cfg_reg.low_thr  <= '0;
            cfg_reg.high_thr <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_OFFSET_X: cfg_reg.offset_x <= pwdata[AXIS_W-1:0];
                REG_OFFSET_Y: cfg_reg.offset_y <= pwdata[AXIS_W-1:0];
                REG_OFFSET_Z: cfg_reg.offset_z <= pwdata[AXIS_W-1:0];
                REG_SHIFT_X:  cfg_reg.shift_x  <= pwdata[3:0];
                REG_SHIFT_Y:  cfg_reg.shift_y  <= pwdata[3:0];
                REG_SHIFT_Z:  cfg_reg.shift_z  <= pwdata[3:0];
                REG_LOW_THR:  cfg_reg.low_thr  <= pwdata;
                REG_HIGH_THR: cfg_reg.high_thr <= pwdata;
                default:      ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_OFFSET_X: prdata = {16'd0, cfg_reg.offset_x};
            REG_OFFSET_Y: prdata = {16'd0, cfg_reg.offset_y};
            REG_OFFSET_Z: prdata = {16'd0, cfg_reg.offset_z};
            REG_SHIFT_X:  prdata = {28'd0, cfg_reg.shift_x};
            REG_SHIFT_Y:  prdata = {28'd0, cfg_reg.shift_y};
            REG_SHIFT_Z:  prdata = {28'd0, cfg_reg.shift_z};
            REG_LOW_THR:  prdata = cfg_reg.low_thr;
            REG_HIGH_THR: prdata = cfg_reg.high_thr;
            default:      prdata = '0;
        endcase
    end

endmodule

// File: rtl/mwam_axis.sv
// ----------------------------------------------------------------------------
// mwam_axis
// One axis: offset removal, arithmetic shift, square and int8 saturation.
// ----------------------------------------------------------------------------
module mwam_axis (
    input  logic signed [mwam_pkg::AXIS_W-1:0] raw,
    input  logic signed [mwam_pkg::AXIS_W-1:0] offset,
    input  logic [3:0]                         shift,
    input  logic                               ovf,
    output logic signed [mwam_pkg::NORM_W-1:0] norm,
    output logic [mwam_pkg::SQ_W-1:0]          square
);
    import mwam_pkg::*;

    logic signed [AXIS_W-1:0] diff;
    logic signed [AXIS_W-1:0] shifted;
    logic signed [31:0]       prod;
    logic                     fits;

    // wrapping difference then arithmetic shift
    assign diff    = raw - offset;
    assign shifted = diff >>> shift;

    // full precision square, never negative
    assign prod   = shifted * shifted;
    assign square = prod[SQ_W-1:0];

    // value fits int8 when bits 15..7 all agree
    assign fits = (&shifted[AXIS_W-1:NORM_W-1]) || !(|shifted[AXIS_W-1:NORM_W-1]);

    always_comb
    begin
        if (ovf)
            norm = '1;
        else if (fits)
            norm = shifted[NORM_W-1:0];
        else if (shifted[AXIS_W-1])
            norm = 8'sh80;
        else
            norm = 8'sh7f;
    end

endmodule

// File: rtl/mwam_window.sv
// ----------------------------------------------------------------------------
// mwam_window
// Strength sum, window compare, saturating alarm counter and output register.
// ----------------------------------------------------------------------------
module mwam_window (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    input  mwam_pkg::mwam_sq_t                 item,
    input  logic [mwam_pkg::STR_W-1:0]         low_thr,
    input  logic [mwam_pkg::STR_W-1:0]         high_thr,
    output logic                               take,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [mwam_pkg::NORM_W-1:0] norm_x,
    output logic signed [mwam_pkg::NORM_W-1:0] norm_y,
    output logic signed [mwam_pkg::NORM_W-1:0] norm_z,
    output logic [mwam_pkg::STR_W-1:0]         strength,
    output logic                               in_range,
    output logic [7:0]                         alarm_level,
    output logic                               alarm_on,
    output logic                               notify
);
    import mwam_pkg::*;

    logic                     out_valid_reg;
    logic [7:0]               count_reg;
    logic [7:0]               count_next;
    logic [STR_W-1:0]         sum;
    logic [STR_W-1:0]         strength_next;
    logic                     ok;
    logic                     ready;
    logic signed [NORM_W-1:0] norm_x_reg;
    logic signed [NORM_W-1:0] norm_y_reg;
    logic signed [NORM_W-1:0] norm_z_reg;
    logic [STR_W-1:0]         strength_reg;
    logic                     in_range_reg;

    // output register frees when empty or being drained
    assign ready = !out_valid_reg || !out_stall;
    assign take  = item_valid && ready;

    // strength and window check
    assign sum = STR_W'(item.sq_x) + STR_W'(item.sq_y) + STR_W'(item.sq_z);
    assign strength_next = item.ovf ? '1 : sum;
    assign ok = (strength_next >= low_thr) && (strength_next <= high_thr);

    // saturating up/down counter
    always_comb
    begin
        count_next = count_reg;
        if (ok)
        begin
            if (count_reg != 8'd0)
                count_next = count_reg - 8'd1;
        end
        else if (count_reg < TRIGGER_MAX)
        begin
            count_next = count_reg + 8'd1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (ready)
                out_valid_reg <= item_valid;
            if (take)
                count_reg <= count_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            norm_x_reg   <= item.norm_x;
            norm_y_reg   <= item.norm_y;
            norm_z_reg   <= item.norm_z;
            strength_reg <= strength_next;
            in_range_reg <= ok;
        end
    end

    assign out_valid   = out_valid_reg;
    assign norm_x      = norm_x_reg;
    assign norm_y      = norm_y_reg;
    assign norm_z      = norm_z_reg;
    assign strength    = strength_reg;
    assign in_range    = in_range_reg;
    assign alarm_level = count_reg;
    assign alarm_on    = count_reg >= TRIGGER_LEVEL;
    assign notify      = count_reg == TRIGGER_LEVEL;

endmodule

// File: rtl/magnet_window_alarm_monitor_unit.sv
// ----------------------------------------------------------------------------
// magnet_window_alarm_monitor_unit
// Magnetometer sample normalizer with a field strength window alarm.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall) carries one three-axis sample and
//   an overflow flag per item; output channel (out_valid / out_stall)
//   carries one result item per sample, in order.
//   Pipeline: input register, square register, output register. An item
//   passes them in that order. One item per cycle is sustained while
//   out_stall is low; the stage-2 adder and window compare set the clock.
//   Each stage moves forward when the stage after it is empty or moving,
//   so items are still accepted while a result waits, until all three
//   stages are full. A stalled result holds its fields unchanged. The
//   alarm counter value is the one left by the item being reported.
//   Offsets, shifts and thresholds are written through the APB-style
//   port; the user must write them only while no item is in flight, which
//   the block does not enforce; pready is tied high. Reset clears all valid
//   flags and the counter and loads offsets 0, shifts 1, thresholds 0.
// ----------------------------------------------------------------------------
module magnet_window_alarm_monitor_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [15:0]  raw_x,
    input  logic signed [15:0]  raw_y,
    input  logic signed [15:0]  raw_z,
    input  logic                field_overflow,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [7:0]   norm_x,
    output logic signed [7:0]   norm_y,
    output logic signed [7:0]   norm_z,
    output logic [31:0]         strength,
    output logic                in_range,
    output logic [7:0]          alarm_level,
    output logic                alarm_on,
    output logic                notify
);
    import mwam_pkg::*;

    mwam_cfg_t                cfg;
    logic                     s1_valid_reg;
    logic signed [AXIS_W-1:0] raw_x_reg;
    logic signed [AXIS_W-1:0] raw_y_reg;
    logic signed [AXIS_W-1:0] raw_z_reg;
    logic                     ovf_reg;
    logic                     s2_valid_reg;
    mwam_sq_t                 s2_reg;
    mwam_sq_t                 s2_next;
    logic                     s1_ready;
    logic                     s2_ready;
    logic                     take;

    // register file
    mwam_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // stage hand-off
    assign s2_ready = !s2_valid_reg || take;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            raw_x_reg <= raw_x;
            raw_y_reg <= raw_y;
            raw_z_reg <= raw_z;
            ovf_reg   <= field_overflow;
        end
    end

    // per-axis correction and squares
    mwam_axis u_axis_x (
        .raw    (raw_x_reg),
        .offset (cfg.offset_x),
        .shift  (cfg.shift_x),
        .ovf    (ovf_reg),
        .norm   (s2_next.norm_x),
        .square (s2_next.sq_x)
    );

    mwam_axis u_axis_y (
        .raw    (raw_y_reg),
        .offset (cfg.offset_y),
        .shift  (cfg.shift_y),
        .ovf    (ovf_reg),
        .norm   (s2_next.norm_y),
        .square (s2_next.sq_y)
    );

    mwam_axis u_axis_z (
        .raw    (raw_z_reg),
        .offset (cfg.offset_z),
        .shift  (cfg.shift_z),
        .ovf    (ovf_reg),
        .norm   (s2_next.norm_z),
        .square (s2_next.sq_z)
    );

    assign s2_next.ovf = ovf_reg;

    // square register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
            s2_reg <= s2_next;
    end

    // window, counter and output register
    mwam_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (s2_valid_reg),
        .item        (s2_reg),
        .low_thr     (cfg.low_thr),
        .high_thr    (cfg.high_thr),
        .take        (take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .norm_x      (norm_x),
        .norm_y      (norm_y),
        .norm_z      (norm_z),
        .strength    (strength),
        .in_range    (in_range),
        .alarm_level (alarm_level),
        .alarm_on    (alarm_on),
        .notify      (notify)
    );

endmodule

// File: rtl/mwam_checker.sv
// ----------------------------------------------------------------------------
// mwam_checker
// Port-level checks on result items of the window alarm monitor.
// ----------------------------------------------------------------------------
module mwam_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [7:0]  norm_x,
    input  logic [31:0]        strength,
    input  logic               in_range,
    input  logic [7:0]         alarm_level,
    input  logic               alarm_on,
    input  logic               notify
);
    import mwam_pkg::*;

    // stalled result keeps its fields
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(strength) && $stable(norm_x)
            && $stable(alarm_level))
        else $error("stalled result changed");

    // counter never passes its ceiling
    a_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> alarm_level <= TRIGGER_MAX)
        else $error("alarm level above ceiling");

    // in-range item always leaves the counter below the ceiling
    a_down: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_range |-> alarm_level < TRIGGER_MAX)
        else $error("counter did not move down");

    // out-of-range item always leaves the counter above zero
    a_up: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_range |-> alarm_level != 8'd0)
        else $error("counter did not move up");

    // notify only at the trigger level, which also raises the alarm
    a_notify: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && notify |-> alarm_on && (alarm_level == TRIGGER_LEVEL))
        else $error("notify without alarm at trigger level");

endmodule

bind magnet_window_alarm_monitor_unit mwam_checker u_mwam_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .norm_x      (norm_x),
    .strength    (strength),
    .in_range    (in_range),
    .alarm_level (alarm_level),
    .alarm_on    (alarm_on),
    .notify      (notify)
);

// File: verif/mwam_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mwam_result_checker
// Watches the sample and result channels of the magnetometer window alarm
// monitor, tracks register writes, predicts each result and compares it.
// ----------------------------------------------------------------------------
module mwam_result_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic signed [15:0]  raw_x,
    input  logic signed [15:0]  raw_y,
    input  logic signed [15:0]  raw_z,
    input  logic                field_overflow,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic signed [7:0]   norm_x,
    input  logic signed [7:0]   norm_y,
    input  logic signed [7:0]   norm_z,
    input  logic [31:0]         strength,
    input  logic                in_range,
    input  logic [7:0]          alarm_level,
    input  logic                alarm_on,
    input  logic                notify,
    output int                  mismatch_count,
    output int                  pending
);
    import mwam_pkg::*;

    // one result item as seen on the output channel
    typedef struct packed {
        logic signed [7:0] nx;
        logic signed [7:0] ny;
        logic signed [7:0] nz;
        logic [31:0]       strength;
        logic              in_range;
        logic [7:0]        level;
        logic              alarm;
        logic              notify;
    } reading_t;

    mwam_cfg_t  cfg;
    logic [7:0] alarm_count;
    reading_t   readings_due[$];
    reading_t   seen;
    reading_t   due;

    // offset removal with 16-bit wrap, then arithmetic shift
    function automatic logic signed [15:0] scale_axis(input logic signed [15:0] raw,
                                                      input logic signed [15:0] off,
                                                      input logic [3:0] sh);
        logic signed [15:0] diff;
        diff = raw - off;
        return diff >>> sh;
    endfunction

    function automatic logic signed [7:0] clamp8(input logic signed [15:0] v);
        if (v > 16'sd127)
            return 8'sd127;
        if (v < -16'sd128)
            return -8'sd128;
        return v[7:0];
    endfunction

    // expected result of one sample; carries the updated counter
    function automatic reading_t predict_reading(input mwam_cfg_t c,
                                                 input logic [7:0] lvl,
                                                 input logic signed [15:0] rx,
                                                 input logic signed [15:0] ry,
                                                 input logic signed [15:0] rz,
                                                 input logic ovf);
        reading_t           r;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        int                 sqx;
        int                 sqy;
        int                 sqz;
        logic [7:0]         nxt;
        if (ovf)
        begin
            r.nx       = -8'sd1;
            r.ny       = -8'sd1;
            r.nz       = -8'sd1;
            r.strength = 32'hFFFF_FFFF;
        end
        else
        begin
            ax = scale_axis(rx, c.offset_x, c.shift_x);
            ay = scale_axis(ry, c.offset_y, c.shift_y);
            az = scale_axis(rz, c.offset_z, c.shift_z);
            sqx = ax;
            sqy = ay;
            sqz = az;
            sqx = sqx * sqx;
            sqy = sqy * sqy;
            sqz = sqz * sqz;
            r.strength = 32'(sqx) + 32'(sqy) + 32'(sqz);
            r.nx = clamp8(ax);
            r.ny = clamp8(ay);
            r.nz = clamp8(az);
        end
        r.in_range = (r.strength >= c.low_thr) && (r.strength <= c.high_thr);
        // saturating up/down counter
        nxt = lvl;
        if (r.in_range)
        begin
            if (nxt != 8'd0)
                nxt = nxt - 8'd1;
        end
        else if (nxt < TRIGGER_MAX)
        begin
            nxt = nxt + 8'd1;
        end
        r.level  = nxt;
        r.alarm  = (nxt >= TRIGGER_LEVEL);
        r.notify = (nxt == TRIGGER_LEVEL);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    initial
    begin
        mismatch_count = 0;
        pending = 0;
    end

    // compare results, predict accepted samples, follow register writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.offset_x = '0;
            cfg.offset_y = '0;
            cfg.offset_z = '0;
            cfg.shift_x  = 4'd1;
            cfg.shift_y  = 4'd1;
            cfg.shift_z  = 4'd1;
            cfg.low_thr  = '0;
            cfg.high_thr = '0;
            alarm_count  = '0;
            readings_due.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = {norm_x, norm_y, norm_z, strength, in_range, alarm_level,
                        alarm_on, notify};
                if (readings_due.size() == 0)
                begin
                    report_mismatch("unexpected result, strength", seen.strength, '0);
                end
                else
                begin
                    due = readings_due.pop_front();
                    if (seen.nx !== due.nx)
                        report_mismatch("norm_x", seen.nx, due.nx);
                    if (seen.ny !== due.ny)
                        report_mismatch("norm_y", seen.ny, due.ny);
                    if (seen.nz !== due.nz)
                        report_mismatch("norm_z", seen.nz, due.nz);
                    if (seen.strength !== due.strength)
                        report_mismatch("strength", seen.strength, due.strength);
                    if (seen.in_range !== due.in_range)
                        report_mismatch("in_range", seen.in_range, due.in_range);
                    if (seen.level !== due.level)
                        report_mismatch("alarm_level", seen.level, due.level);
                    if (seen.alarm !== due.alarm)
                        report_mismatch("alarm_on", seen.alarm, due.alarm);
                    if (seen.notify !== due.notify)
                        report_mismatch("notify", seen.notify, due.notify);
                end
            end
            if (in_valid && !in_stall)
            begin
                due = predict_reading(cfg, alarm_count, raw_x, raw_y, raw_z, field_overflow);
                alarm_count = due.level;
                readings_due.push_back(due);
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_OFFSET_X: cfg.offset_x = pwdata[15:0];
                    REG_OFFSET_Y: cfg.offset_y = pwdata[15:0];
                    REG_OFFSET_Z: cfg.offset_z = pwdata[15:0];
                    REG_SHIFT_X:  cfg.shift_x  = pwdata[3:0];
                    REG_SHIFT_Y:  cfg.shift_y  = pwdata[3:0];
                    REG_SHIFT_Z:  cfg.shift_z  = pwdata[3:0];
                    REG_LOW_THR:  cfg.low_thr  = pwdata;
                    REG_HIGH_THR: cfg.high_thr = pwdata;
                    default: ;
                endcase
            end
        end
        pending = readings_due.size();
    end

endmodule

// File: verif/tb_magnet_window_alarm_monitor_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_magnet_window_alarm_monitor_unit
// Drives magnetometer samples and register settings into the window alarm
// monitor under random idling on both channels; a checker beside the block
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_magnet_window_alarm_monitor_unit;
    import mwam_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
    logic               field_overflow;
    logic               out_valid;
    logic               out_stall;
    logic signed [7:0]  norm_x;
    logic signed [7:0]  norm_y;
    logic signed [7:0]  norm_z;
    logic [31:0]        strength;
    logic               in_range;
    logic [7:0]         alarm_level;
    logic               alarm_on;
    logic               notify;

    int                 mismatch_count;
    int                 results_due;

    // test control
    bit                 quiet;
    bit                 long_hold_req;
    logic signed [15:0] cur_off_x;
    logic signed [15:0] cur_off_y;
    logic signed [15:0] cur_off_z;

    magnet_window_alarm_monitor_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .raw_x          (raw_x),
        .raw_y          (raw_y),
        .raw_z          (raw_z),
        .field_overflow (field_overflow),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .norm_x         (norm_x),
        .norm_y         (norm_y),
        .norm_z         (norm_z),
        .strength       (strength),
        .in_range       (in_range),
        .alarm_level    (alarm_level),
        .alarm_on       (alarm_on),
        .notify         (notify)
    );

    mwam_result_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .raw_x          (raw_x),
        .raw_y          (raw_y),
        .raw_z          (raw_z),
        .field_overflow (field_overflow),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .norm_x         (norm_x),
        .norm_y         (norm_y),
        .norm_z         (norm_z),
        .strength       (strength),
        .in_range       (in_range),
        .alarm_level    (alarm_level),
        .alarm_on       (alarm_on),
        .notify         (notify),
        .mismatch_count (mismatch_count),
        .pending        (results_due)
    );

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // run limit
    initial
    begin
        #6_000_000;
        $display("Some tests failed");
        $finish;
    end

    // result side: random stall bursts, one long hold on request
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                out_stall = 1'b1;
                repeat (64) @(negedge clk);
                out_stall = 1'b0;
                long_hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // one register write: setup then access cycle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic load_setup(input logic signed [15:0] ox, input logic signed [15:0] oy,
                              input logic signed [15:0] oz, input logic [3:0] sx,
                              input logic [3:0] sy, input logic [3:0] sz,
                              input logic [31:0] low, input logic [31:0] high);
        write_reg(REG_OFFSET_X, 32'(ox));
        write_reg(REG_OFFSET_Y, 32'(oy));
        write_reg(REG_OFFSET_Z, 32'(oz));
        write_reg(REG_SHIFT_X, 32'(sx));
        write_reg(REG_SHIFT_Y, 32'(sy));
        write_reg(REG_SHIFT_Z, 32'(sz));
        write_reg(REG_LOW_THR, low);
        write_reg(REG_HIGH_THR, high);
        cur_off_x = ox;
        cur_off_y = oy;
        cur_off_z = oz;
    endtask

    // offer one sample and hold it until accepted; valid stays high
    task automatic drive_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                                input logic signed [15:0] z, input logic ovf);
        raw_x          = x;
        raw_y          = y;
        raw_z          = z;
        field_overflow = ovf;
        in_valid       = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
    endtask

    // wait until every result is back, then let the pipeline settle
    task automatic drain();
        in_valid = 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // random setting, mostly with a window scaled to the likely strength
    task automatic random_setup();
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic signed [15:0] oz;
        logic [3:0]         sx;
        logic [3:0]         sy;
        logic [3:0]         sz;
        logic [3:0]         smin;
        logic [31:0]        span;
        logic [31:0]        low;
        logic [31:0]        high;
        ox = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 511) - 256);
        oy = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 511) - 256);
        oz = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 511) - 256);
        sx = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 7));
        sy = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 7));
        sz = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 7));
        smin = sx;
        if (sy < smin)
            smin = sy;
        if (sz < smin)
            smin = sz;
        span = 32'd1 << (30 - 2 * smin);
        case ($urandom_range(0, 5))
            0:
            begin
                low  = $urandom;
                high = $urandom;
            end
            1:
            begin
                low  = '0;
                high = '1;
            end
            default:
            begin
                low  = $urandom_range(0, span);
                high = low + $urandom_range(0, 2 * span);
            end
        endcase
        load_setup(ox, oy, oz, sx, sy, sz, low, high);
    endtask

    // random sample: full range or close to the current offsets
    task automatic random_sample();
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               ovf;
        ovf = ($urandom_range(0, 15) == 0);
        if ($urandom_range(0, 2) == 0)
        begin
            x = 16'($urandom);
            y = 16'($urandom);
            z = 16'($urandom);
        end
        else
        begin
            x = cur_off_x + 16'($urandom_range(0, 4095) - 2048);
            y = cur_off_y + 16'($urandom_range(0, 4095) - 2048);
            z = cur_off_z + 16'($urandom_range(0, 4095) - 2048);
        end
        drive_sample(x, y, z, ovf);
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        raw_x          = '0;
        raw_y          = '0;
        raw_z          = '0;
        field_overflow = 1'b0;
        quiet          = 1'b0;
        long_hold_req  = 1'b0;
        cur_off_x      = '0;
        cur_off_y      = '0;
        cur_off_z      = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // settings after reset
        drive_sample(16'sd3, -16'sd5, 16'sd0, 1'b0);
        drive_sample(-16'sd32768, 16'sd32767, -16'sd1, 1'b0);
        drain();

        // no shift, window wide open: axis extremes and saturation
        load_setup(16'sd0, 16'sd0, 16'sd0, 4'd0, 4'd0, 4'd0, 32'd0, 32'hFFFF_FFFF);
        drive_sample(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
        drive_sample(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
        drive_sample(16'sd0, 16'sd0, 16'sd0, 1'b0);
        drive_sample(-16'sd1, -16'sd1, -16'sd1, 1'b0);
        drive_sample(16'sd128, -16'sd129, -16'sd128, 1'b0);
        drive_sample(16'sd200, -16'sd300, 16'sd5, 1'b0);
        drive_sample(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
        drain();

        // offset wrap, largest shift, inverted window: counter climbs to its ceiling
        load_setup(16'sd1, -16'sd32768, 16'sd32767, 4'd15, 4'd8, 4'd3, 32'd1000, 32'd500);
        drive_sample(-16'sd32768, 16'sd0, 16'sd0, 1'b0);
        repeat (7)
            drive_sample(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
        drain();

        // window closed at zero: counter falls from its ceiling toward zero
        load_setup(16'sd0, 16'sd0, 16'sd0, 4'd15, 4'd15, 4'd15, 32'd0, 32'd0);
        drive_sample(-16'sd1, -16'sd32768, -16'sd7, 1'b0);
        repeat (7)
            drive_sample(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)),
                         16'($urandom_range(0, 32767)), 1'b0);

        // random phases, each under a fresh setting
        for (int phase = 0; phase < 8; phase++)
        begin
            drain();
            random_setup();
            if (phase == 7)
                quiet = 1'b1;
            for (int n = 0; n < 128; n++)
            begin
                sender_gap();
                random_sample();
                if (phase == 2 && n == 40)
                    long_hold_req = 1'b1;
                if (phase == 4 && n == 64)
                begin
                    in_valid = 1'b0;
                    while (results_due != 0)
                        @(negedge clk);
                end
            end
        end

        in_valid = 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
